FILE: src/trpd_pkg.sv
// ----------------------------------------------------------------------------
// trpd_pkg: shared types and codes for the tga rle pixel decoder
// Holds pixel format codes, register indexes and the palette write and lookup bundle.
// ----------------------------------------------------------------------------
package trpd_pkg;

   typedef enum logic [1:0] {
      FMT_GREY  = 2'd0,
      FMT_BGR   = 2'd1,
      FMT_BGRA  = 2'd2,
      FMT_INDEX = 2'd3
   } pixel_format_type;

   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_STREAM_BYTE   = 1'b0,
      CMD_PALETTE_WRITE = 1'b1
   } command_type;

   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam logic [7:0]  RUN_FLAG_MASK  = 8'h80;
   localparam logic [6:0]  RUN_LEN_MASK   = 7'd127;
   localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;

   // palette port: one write and one lookup per cycle
   typedef struct packed {
      logic        wr_en;
      logic [7:0]  wr_slot;
      logic [23:0] wr_color;
      logic        rd_en;
      logic [7:0]  rd_slot;
   } pal_req_type;

endpackage

FILE: src/trpd_palette.sv
// ----------------------------------------------------------------------------
// trpd_palette: color palette memory
// One write and one registered read per cycle; slots past the depth read as
// zero and ignore writes.
// ----------------------------------------------------------------------------
module trpd_palette #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                 clock,
   input  trpd_pkg::pal_req_type pal_req,
   output logic [23:0]          rd_color
);
   import trpd_pkg::*;

   localparam int unsigned ADDR_WIDTH = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [8:0]  SLOT_LIMIT = 9'(PALETTE_ENTRIES);

   logic [23:0] mem [PALETTE_ENTRIES];
   logic [23:0] rd_data_ff;
   logic        rd_hit_ff;
   logic        wr_hit;
   logic        rd_hit;

   assign wr_hit = ({1'b0, pal_req.wr_slot} < SLOT_LIMIT);
   assign rd_hit = ({1'b0, pal_req.rd_slot} < SLOT_LIMIT);

   always_ff @(posedge clock) begin
      if (pal_req.wr_en && wr_hit) begin
         mem[pal_req.wr_slot[ADDR_WIDTH-1:0]] <= pal_req.wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_req.rd_en) begin
         rd_data_ff <= mem[pal_req.rd_slot[ADDR_WIDTH-1:0]];
         rd_hit_ff  <= rd_hit;
      end
   end

   assign rd_color = rd_hit_ff ? rd_data_ff : 24'd0;

endmodule

FILE: src/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder: tga run-length stream to pixel spans
// Decodes packet headers and pixel bytes, looks up indexed colors and emits
// one span (pixel, start index, count, last flag) per completed pixel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | command, stream_byte, palette slot/color
//  rsp     | out       | rsp_valid/stall    | pixel_value, first_index, repeat_count, last
//  csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// one beat is taken per cycle while req_stall is low
// the path is an input register, the decode logic and a result register; the
// palette lookup is read at accept time and lands beside the input register
// the pixel count is registered at the same edge as a width or height write
// reset is synchronous and returns the decoder to the start of an image
// a stalled result holds the stage behind it; req_stall rises once that stage is full
module tga_rle_pixel_decoder #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_stream_byte,
   input  logic [7:0]  req_palette_slot,
   input  logic [23:0] req_palette_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_value,
   output logic [31:0] rsp_first_index,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_image_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [trpd_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import trpd_pkg::*;

   // configuration
   pixel_format_type fmt_ff;
   logic [15:0]      width_ff;
   logic [15:0]      height_ff;
   logic [31:0]      total_ff;
   logic [15:0]      width_in;
   logic [15:0]      height_in;
   logic [15:0]      width_nz;
   logic [15:0]      height_nz;

   // input stage
   logic        in_valid_ff;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;
   logic        req_accept;
   logic        in_ready;
   logic        stage_go;
   pal_req_type pal_req;
   logic [23:0] pal_color;

   // decode state
   logic        expect_header_ff, expect_header_in;
   logic        is_run_ff, is_run_in;
   logic [7:0]  left_ff, left_in;
   logic [1:0]  bip_ff, bip_in;
   logic [23:0] asm_ff, asm_in;
   logic [31:0] pos_ff, pos_in;

   // result stage
   logic        res_valid;
   logic [31:0] res_value;
   logic [7:0]  res_count;
   logic        res_last;
   logic        out_valid_ff;
   logic [31:0] out_value_ff;
   logic [31:0] out_index_ff;
   logic [7:0]  out_count_ff;
   logic        out_last_ff;

   logic [2:0]  bpp;
   logic [7:0]  run_count;
   logic [31:0] remaining;
   logic        pos_past_end;
   logic        proc_fire;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_BGRA;
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PIXEL_FORMAT: fmt_ff    <= pixel_format_type'(csr_write_data[1:0]);
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[15:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // the count follows a dimension write at the same edge as the format would
   assign width_in  = (csr_write_enable && (csr_index_type'(csr_index) == CSR_IMAGE_WIDTH))
                      ? csr_write_data[15:0] : width_ff;
   assign height_in = (csr_write_enable && (csr_index_type'(csr_index) == CSR_IMAGE_HEIGHT))
                      ? csr_write_data[15:0] : height_ff;

   assign width_nz  = (width_in == 16'd0) ? 16'd1 : width_in;
   assign height_nz = (height_in == 16'd0) ? 16'd1 : height_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 32'd1;
      end else begin
         total_ff <= {16'd0, width_nz} * {16'd0, height_nz};
      end
   end

   // ----------------------------------------------------------- input stage
   assign stage_go   = !out_valid_ff || !rsp_stall;
   assign in_ready   = !in_valid_ff || stage_go;
   assign req_stall  = !in_ready;
   assign req_accept = req_valid && in_ready;
   assign proc_fire  = in_valid_ff && stage_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff  <= req_command;
         in_byte_ff <= req_stream_byte;
      end
   end

   always_comb begin
      pal_req.wr_en    = req_accept && (command_type'(req_command) == CMD_PALETTE_WRITE);
      pal_req.wr_slot  = req_palette_slot;
      pal_req.wr_color = req_palette_color;
      pal_req.rd_en    = req_accept;
      pal_req.rd_slot  = req_stream_byte;
   end

   trpd_palette #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .pal_req (pal_req),
      .rd_color(pal_color)
   );

   // ---------------------------------------------------------------- decode
   always_comb begin
      unique case (fmt_ff)
         FMT_BGR:  bpp = 3'd3;
         FMT_BGRA: bpp = 3'd4;
         default:  bpp = 3'd1;
      endcase
   end

   assign run_count    = is_run_ff ? left_ff : 8'd1;
   assign pos_past_end = (pos_ff >= total_ff);
   assign remaining    = total_ff - pos_ff;

   always_comb begin
      expect_header_in = expect_header_ff;
      is_run_in        = is_run_ff;
      left_in          = left_ff;
      bip_in           = bip_ff;
      asm_in           = asm_ff;
      pos_in           = pos_ff;
      res_valid        = 1'b0;
      res_value        = 32'd0;
      res_count        = run_count;
      res_last         = 1'b0;

      if (command_type'(in_cmd_ff) == CMD_STREAM_BYTE) begin
         if (expect_header_ff || (left_ff == 8'd0)) begin
            is_run_in        = (in_byte_ff & RUN_FLAG_MASK) != 8'd0;
            left_in          = {1'b0, in_byte_ff[6:0] & RUN_LEN_MASK} + 8'd1;
            bip_in           = 2'd0;
            asm_in           = 24'd0;
            expect_header_in = 1'b0;
         end else if (({1'b0, bip_ff} + 3'd1) < bpp) begin
            case (bip_ff)
               2'd0:    asm_in[7:0]   = asm_ff[7:0]   | in_byte_ff;
               2'd1:    asm_in[15:8]  = asm_ff[15:8]  | in_byte_ff;
               default: asm_in[23:16] = asm_ff[23:16] | in_byte_ff;
            endcase
            bip_in = bip_ff + 2'd1;
         end else begin
            res_valid = 1'b1;
            unique case (fmt_ff)
               FMT_GREY:  res_value = {24'd0, in_byte_ff};
               FMT_BGR:   res_value = {ALPHA_OPAQUE, asm_ff[23:16] | in_byte_ff, asm_ff[15:0]};
               FMT_BGRA:  res_value = {in_byte_ff, asm_ff};
               default:   res_value = {ALPHA_OPAQUE, pal_color};
            endcase
            bip_in = 2'd0;
            asm_in = 24'd0;

            if (pos_past_end) begin
               res_count = 8'd1;
               res_last  = 1'b1;
            end else begin
               if ({24'd0, run_count} > remaining) begin
                  res_count = remaining[7:0];
               end
               res_last = ({24'd0, res_count} == remaining);
            end

            if (res_last) begin
               expect_header_in = 1'b1;
               is_run_in        = 1'b0;
               left_in          = 8'd0;
               pos_in           = 32'd0;
            end else begin
               pos_in  = pos_ff + {24'd0, res_count};
               left_in = is_run_ff ? 8'd0 : left_ff - 8'd1;
               if (left_in == 8'd0) begin
                  expect_header_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff <= 1'b1;
         is_run_ff        <= 1'b0;
         left_ff          <= 8'd0;
         bip_ff           <= 2'd0;
         asm_ff           <= 24'd0;
         pos_ff           <= 32'd0;
      end else if (proc_fire) begin
         expect_header_ff <= expect_header_in;
         is_run_ff        <= is_run_in;
         left_ff          <= left_in;
         bip_ff           <= bip_in;
         asm_ff           <= asm_in;
         pos_ff           <= pos_in;
      end
   end

   // ---------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_go) begin
         out_valid_ff <= in_valid_ff && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && res_valid) begin
         out_value_ff <= res_value;
         out_index_ff <= pos_ff;
         out_count_ff <= res_count;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pixel_value  = out_value_ff;
   assign rsp_first_index  = out_index_ff;
   assign rsp_repeat_count = out_count_ff;
   assign rsp_image_last   = out_last_ff;

   // ------------------------------------------------------------ assertions
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stalled with an empty stage");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && res_valid && res_last) |=> (pos_ff == 32'd0) && expect_header_ff)
      else $error("image end did not restart the decoder");

   a_span_advances: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && res_valid && !res_last)
      |=> (pos_ff == $past(pos_ff) + {24'd0, $past(res_count)}))
      else $error("position did not advance by the span length");

   a_header_loads: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && !in_cmd_ff && (expect_header_ff || left_ff == 8'd0))
      |=> !expect_header_ff && (left_ff != 8'd0))
      else $error("header beat did not open a packet");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (proc_fire && res_valid) |=> (rsp_valid && rsp_repeat_count != 8'd0))
      else $error("span issued with a zero count");

endmodule
